/* hdl/rhd_pkg.sv */
`timescale 1ns / 1ps

package rhd_pkg;

  localparam logic [31:0] GEN_A_MUL   = 32'd1701532575;
  localparam logic [31:0] GEN_A_ADD   = 32'd571550083;
  localparam logic [31:0] GEN_B_MUL   = 32'd3145804233;
  localparam logic [31:0] GEN_B_ADD   = 32'd4178903934;
  localparam logic [31:0] GEN_A_RESET = 32'd1151752134;
  localparam logic [31:0] GEN_B_RESET = 32'd2070363486;

  localparam int unsigned TRY_W    = 10;            // 1024 tries per word
  localparam int unsigned ROOT_STEPS = 32;          // one root bit per step
  localparam int unsigned DIV_STEPS  = 17;          // quotient up to 32768
  localparam int unsigned CNT_W    = 5;

  localparam logic [15:0] POS_MAX = 16'h7FFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SQR,
    ST_ACC,
    ST_CHECK,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_n;
    logic       draw;
    logic       clr;
    logic       sqr;
    logic       acc;
    logic [1:0] comp;
    logic       set_fail;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic point_ok;
  } status_t;

endpackage

/* hdl/rhd_dp.sv */
`timescale 1ns / 1ps

module rhd_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rhd_pkg::cmd_t        cmd,
  output rhd_pkg::status_t     status,
  input  logic signed [15:0]   in_normal_x,
  input  logic signed [15:0]   in_normal_y,
  input  logic signed [15:0]   in_normal_z,
  output logic signed [15:0]   res_x,
  output logic signed [15:0]   res_y,
  output logic signed [15:0]   res_z
);

  logic [31:0]        gen_a_r, gen_b_r, gen_a_nxt, gen_b_nxt, word;
  logic signed [15:0] n_r [3];
  logic signed [31:0] p_r [3];
  logic [31:0]        mag_sel;
  logic [63:0]        sq_r;
  logic signed [47:0] prod_r;
  logic [63:0]        d2_r;
  logic signed [49:0] dot_r;
  logic               fail_r;
  logic [63:0]        rad_r;
  logic [35:0]        rem_r, rem_t, trial;
  logic [31:0]        root_r, r_eff;
  logic [47:0]        dv_r;
  logic [47:0]        num_r [3];
  logic [16:0]        q_r [3];
  logic [15:0]        lane_out [3];
  logic               neg;

  // advance both generators, combine into one word
  assign gen_a_nxt = gen_a_r * rhd_pkg::GEN_A_MUL + rhd_pkg::GEN_A_ADD;
  assign gen_b_nxt = gen_b_r * rhd_pkg::GEN_B_MUL + rhd_pkg::GEN_B_ADD;
  assign word      = {gen_a_nxt[15:0], 16'h0000} ^ gen_b_nxt;

  assign mag_sel = p_r[cmd.comp][31] ? (~p_r[cmd.comp] + 32'd1) : p_r[cmd.comp];

  assign status.point_ok = (d2_r != 64'd0) && (d2_r <= {2'b01, 62'd0});
  assign neg = dot_r[49];

  assign rem_t = {rem_r[33:0], rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign r_eff = (root_r == 32'd0) ? 32'd1 : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r <= rhd_pkg::GEN_A_RESET;
      gen_b_r <= rhd_pkg::GEN_B_RESET;
      fail_r  <= 1'b0;
    end else begin
      if (cmd.draw) begin
        gen_a_r <= gen_a_nxt;
        gen_b_r <= gen_b_nxt;
      end
      if (cmd.load_n) fail_r <= 1'b0;
      else if (cmd.set_fail) fail_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n_r[0] <= in_normal_x;
      n_r[1] <= in_normal_y;
      n_r[2] <= in_normal_z;
    end
    if (cmd.draw) begin
      p_r[cmd.comp] <= $signed({~word[31], word[30:0]});
      if (cmd.clr) begin
        d2_r  <= 64'd0;
        dot_r <= 50'sd0;
      end
    end
    if (cmd.sqr) begin
      sq_r   <= mag_sel * mag_sel;
      prod_r <= n_r[cmd.comp] * p_r[cmd.comp];
    end
    if (cmd.acc) begin
      d2_r  <= d2_r + sq_r;
      dot_r <= dot_r + 50'(prod_r);
    end
    // digit-by-digit square root, one result bit a step
    if (cmd.root_init) begin
      rad_r  <= d2_r;
      rem_r  <= 36'd0;
      root_r <= 32'd0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.div_init) dv_r <= {r_eff, 16'h0000};
    else if (cmd.div_step) dv_r <= {1'b0, dv_r[47:1]};
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [31:0] mag_i;
    logic        sgn_i;
    assign mag_i = p_r[i][31] ? (~p_r[i] + 32'd1) : p_r[i];
    assign sgn_i = p_r[i][31] ^ neg;

    // restoring division, one quotient bit a step
    always_ff @(posedge clk) begin
      if (cmd.div_init) begin
        num_r[i] <= {1'b0, mag_i, 15'd0} + 48'(r_eff[31:1]);
        q_r[i]   <= 17'd0;
      end else if (cmd.div_step) begin
        if (num_r[i] >= dv_r) begin
          num_r[i] <= num_r[i] - dv_r;
          q_r[i]   <= {q_r[i][15:0], 1'b1};
        end else begin
          q_r[i] <= {q_r[i][15:0], 1'b0};
        end
      end
    end

    always_comb begin
      if (sgn_i) lane_out[i] = ~q_r[i][15:0] + 16'd1;
      else if (q_r[i][16] || (q_r[i][15:0] > rhd_pkg::POS_MAX)) lane_out[i] = rhd_pkg::POS_MAX;
      else lane_out[i] = q_r[i][15:0];
    end
  end

  assign res_x = fail_r ? 16'sd0 : $signed(lane_out[0]);
  assign res_y = fail_r ? 16'sd0 : $signed(lane_out[1]);
  assign res_z = fail_r ? $signed(rhd_pkg::POS_MAX) : $signed(lane_out[2]);

endmodule

/* hdl/rhd_ctrl.sv */
`timescale 1ns / 1ps

module rhd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  rhd_pkg::status_t  status,
  output rhd_pkg::cmd_t     cmd
);

  rhd_pkg::state_t                  state_r, state_nxt;
  logic [1:0]                       comp_r, comp_nxt;
  logic [rhd_pkg::TRY_W-1:0]        try_r, try_nxt;
  logic [rhd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhd_pkg::ST_IDLE;
      comp_r  <= 2'd0;
      try_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      try_r   <= try_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    try_nxt   = try_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    in_ready  = 1'b0;
    unique case (state_r)
      rhd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_n = 1'b1;
          comp_nxt   = 2'd0;
          try_nxt    = '0;
          state_nxt  = rhd_pkg::ST_DRAW;
        end
      end
      rhd_pkg::ST_DRAW: begin
        cmd.draw  = 1'b1;
        cmd.clr   = (comp_r == 2'd0);
        state_nxt = rhd_pkg::ST_SQR;
      end
      rhd_pkg::ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = rhd_pkg::ST_ACC;
      end
      rhd_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (comp_r == 2'd2) begin
          comp_nxt  = 2'd0;
          state_nxt = rhd_pkg::ST_CHECK;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = rhd_pkg::ST_DRAW;
        end
      end
      rhd_pkg::ST_CHECK: begin
        if (status.point_ok) begin
          cmd.root_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = rhd_pkg::ST_ROOT;
        end else if (&try_r) begin
          cmd.set_fail = 1'b1;
          state_nxt    = rhd_pkg::ST_OUT;
        end else begin
          try_nxt   = try_r + rhd_pkg::TRY_W'(1);
          state_nxt = rhd_pkg::ST_DRAW;
        end
      end
      rhd_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + rhd_pkg::CNT_W'(1);
        if (cnt_r == rhd_pkg::CNT_W'(rhd_pkg::ROOT_STEPS - 1)) state_nxt = rhd_pkg::ST_DIV_INIT;
      end
      rhd_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = rhd_pkg::ST_DIV;
      end
      rhd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + rhd_pkg::CNT_W'(1);
        if (cnt_r == rhd_pkg::CNT_W'(rhd_pkg::DIV_STEPS - 1)) state_nxt = rhd_pkg::ST_OUT;
      end
      rhd_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = rhd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rhd_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/random_hemisphere_direction.sv */
`timescale 1ns / 1ps
// Random direction in the hemisphere of a surface normal.
// Input channel (in_valid/in_ready): one word carries a normal, signed Q1.14
// per component; only the sign of its dot product with the drawn point counts.
// Output channel (out_valid/out_ready): one word per input, a unit direction
// in signed Q1.15, saturated at 32767.
// Per input, triples are drawn from two 32-bit LCGs until the point lies
// inside the unit ball and off the origin (at most 1024 tries, then 0,0,32767).
// Each try runs draw, square and accumulate for each of the three components,
// then one check. An accepted point then passes the bit-serial square root,
// a setup step and three parallel bit-serial dividers, then is handed off;
// one word is in work at a time.
// Reset restores both generator seeds and empties the output register.
// A stalled receiver holds the result in the output register; the next
// word is still accepted and processed, and waits only to hand off.
module random_hemisphere_direction (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z
);

  rhd_pkg::cmd_t      cmd;
  rhd_pkg::status_t   status;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] res_x, res_y, res_z;
  logic signed [15:0] dir_x_r, dir_y_r, dir_z_r;

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  rhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  rhd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_z       (res_z)
  );

  // output register: load on hand off, drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dir_x_r <= res_x;
      dir_y_r <= res_y;
      dir_z_r <= res_z;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_x_r;
  assign out_dir_y = dir_y_r;
  assign out_dir_z = dir_z_r;

  // an accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after accept");

  // a hand off always shows up on the output the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result lost at hand off");

  // a hand off only happens into a free slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result overwrote a pending word");

endmodule
